/* hdl/keystroke_line_editor_defines.svh */
// assertion macros for the keystroke line editor
// no dependencies; included by the top level
`ifndef KEYSTROKE_LINE_EDITOR_DEFINES_SVH
`define KEYSTROKE_LINE_EDITOR_DEFINES_SVH

// same-cycle implication, checked outside reset
`define KLE_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("line editor check failed");

// next-cycle implication, checked outside reset
`define KLE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("line editor check failed");

`endif

/* hdl/kle_pkg.sv */
// shared types and codes of the keystroke line editor
// no dependencies; used by kle_ctrl and keystroke_line_editor
`default_nettype none

package kle_pkg;

	// command codes
	localparam logic [1:0] CMD_KEY   = 2'd0;
	localparam logic [1:0] CMD_READ  = 2'd1;
	localparam logic [1:0] CMD_CLEAR = 2'd2;

	// keystroke codes with a meaning of their own
	localparam logic [7:0] KEY_LEFT  = 8'h3C;
	localparam logic [7:0] KEY_RIGHT = 8'h3E;
	localparam logic [7:0] KEY_BACK  = 8'h2D;

	// result of one step, from the controller to the output registers
	typedef struct packed {
		logic       fire;
		logic [7:0] ch;
		logic       valid;
		logic       dropped;
	} result_t;

endpackage

`default_nettype wire

/* hdl/kle_mem.sv */
// text store: one write port, one read port with registered read data
// no dependencies
`default_nettype none

module kle_mem #(
	parameter int BUF_DEPTH = 1024,
	parameter int ADDR_W    = 10
) (
	input  wire logic              clk,
	input  wire logic              rd_en,
	input  wire logic [ADDR_W-1:0] rd_addr,
	output      logic [7:0]        rd_data,
	input  wire logic              wr_en,
	input  wire logic [ADDR_W-1:0] wr_addr,
	input  wire logic [7:0]        wr_data
);

	logic [7:0] store_q [BUF_DEPTH];
	logic [7:0] rd_data_q;

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			store_q[wr_addr] <= wr_data;
		end
	end

	// read port, registered read data
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= store_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

`default_nettype wire

/* hdl/kle_ctrl.sv */
// gap buffer controller: cursor counts, address generation, write-back sequencing
// depends on kle_pkg; drives kle_mem
`default_nettype none

module kle_ctrl #(
	parameter int BUF_DEPTH = 1024,
	parameter int ADDR_W    = 10,
	parameter int CNT_W     = 11
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire logic [1:0]        cmd,
	input  wire logic [7:0]        key_byte,
	input  wire logic [ADDR_W-1:0] read_index,
	output      logic              busy,
	output      logic              rd_en,
	output      logic [ADDR_W-1:0] rd_addr,
	input  wire logic [7:0]        rd_data,
	output      logic              wr_en,
	output      logic [ADDR_W-1:0] wr_addr,
	output      logic [7:0]        wr_data,
	output      logic [CNT_W-1:0]  left_count,
	output      logic [CNT_W-1:0]  right_count,
	output      kle_pkg::result_t  result
);

	import kle_pkg::*;

	localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(BUF_DEPTH);

	typedef enum logic {S_IDLE, S_EXEC} state_t;

	state_t            state_q;
	logic [CNT_W-1:0]  left_q, right_q;
	logic              wr_pend_q, wr_from_rd_q, valid_q, drop_q;
	logic [ADDR_W-1:0] wr_addr_q;
	logic [7:0]        key_q;

	logic              accept;
	logic [CNT_W-1:0]  left_n, right_n, sum, idx_ext, pos;
	logic [CNT_W-1:0]  rd_pos, wr_pos;
	logic              wr_pend_n, wr_from_rd_n, valid_n, drop_n;

	assign accept  = start && (state_q == S_IDLE);
	assign sum     = left_q + right_q;
	assign idx_ext = CNT_W'(read_index);
	assign pos     = DEPTH_C - right_q + idx_ext - left_q;

	// decode the command against the current counts
	always_comb begin
		left_n       = left_q;
		right_n      = right_q;
		rd_en        = 1'b0;
		rd_pos       = '0;
		wr_pos       = '0;
		wr_pend_n    = 1'b0;
		wr_from_rd_n = 1'b0;
		valid_n      = 1'b0;
		drop_n       = 1'b0;
		if (accept) begin
			unique case (cmd)
				CMD_KEY: begin
					unique case (key_byte)
						KEY_LEFT: begin
							if (left_q != '0) begin
								rd_en        = 1'b1;
								rd_pos       = left_q - 1'b1;
								wr_pos       = DEPTH_C - right_q - 1'b1;
								wr_pend_n    = 1'b1;
								wr_from_rd_n = 1'b1;
								left_n       = left_q - 1'b1;
								right_n      = right_q + 1'b1;
							end
						end
						KEY_RIGHT: begin
							if (right_q != '0) begin
								rd_en        = 1'b1;
								rd_pos       = DEPTH_C - right_q;
								wr_pos       = left_q;
								wr_pend_n    = 1'b1;
								wr_from_rd_n = 1'b1;
								left_n       = left_q + 1'b1;
								right_n      = right_q - 1'b1;
							end
						end
						KEY_BACK: begin
							if (left_q != '0) begin
								left_n = left_q - 1'b1;
							end
						end
						default: begin
							if (sum < DEPTH_C) begin
								wr_pos    = left_q;
								wr_pend_n = 1'b1;
								left_n    = left_q + 1'b1;
							end else begin
								drop_n = 1'b1;
							end
						end
					endcase
				end
				CMD_READ: begin
					if (idx_ext < left_q) begin
						rd_en   = 1'b1;
						rd_pos  = idx_ext;
						valid_n = 1'b1;
					end else if (idx_ext < sum) begin
						rd_en   = 1'b1;
						rd_pos  = pos;
						valid_n = 1'b1;
					end
				end
				CMD_CLEAR: begin
					left_n  = '0;
					right_n = '0;
				end
				default: begin
				end
			endcase
		end
	end

	assign rd_addr = rd_pos[ADDR_W-1:0];

	// state, counts and the pending write-back
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			left_q       <= '0;
			right_q      <= '0;
			wr_pend_q    <= 1'b0;
			wr_from_rd_q <= 1'b0;
			wr_addr_q    <= '0;
			key_q        <= '0;
			valid_q      <= 1'b0;
			drop_q       <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q      <= S_EXEC;
						left_q       <= left_n;
						right_q      <= right_n;
						wr_pend_q    <= wr_pend_n;
						wr_from_rd_q <= wr_from_rd_n;
						wr_addr_q    <= wr_pos[ADDR_W-1:0];
						key_q        <= key_byte;
						valid_q      <= valid_n;
						drop_q       <= drop_n;
					end
				end
				S_EXEC: begin
					state_q   <= S_IDLE;
					wr_pend_q <= 1'b0;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// write-back in the execute cycle, read data arrives in the same cycle
	assign busy    = (state_q == S_EXEC);
	assign wr_en   = busy && wr_pend_q;
	assign wr_addr = wr_addr_q;
	assign wr_data = wr_from_rd_q ? rd_data : key_q;

	assign left_count  = left_q;
	assign right_count = right_q;

	assign result.fire    = busy;
	assign result.ch      = valid_q ? rd_data : 8'h00;
	assign result.valid   = valid_q;
	assign result.dropped = drop_q;

endmodule

`default_nettype wire

/* hdl/keystroke_line_editor.sv */
// keystroke line editor top level: controller, text store, result registers
// depends on kle_pkg, kle_ctrl, kle_mem and keystroke_line_editor_defines.svh
//
// Usage:
//   A command beat is taken at a rising edge with start high and busy low:
//   cmd 0 applies key_byte ('<' left, '>' right, '-' backspace, else insert),
//   cmd 1 reads the character at read_index, cmd 2 clears the text.
//   Each command gives one result beat: done is high for exactly one cycle
//   with char_out, index_valid, text_length, cursor_pos and dropped.
//   The result passes through the execute state, then the result registers;
//   busy is high for the cycle after acceptance, while the text store returns
//   its read data and the controller writes the moved or inserted byte back
//   (one read then one write, through the read port and then the write port
//   of the store). A new command may be taken in the cycle that shows done.
//   The receiver cannot stall: results must be taken as they appear.
//   Reset clears the cursor counts, the controller state and the done strobe;
//   the store needs no clearing pass, since only written positions are ever read.
`default_nettype none
`include "keystroke_line_editor_defines.svh"

module keystroke_line_editor #(
	parameter int BUF_DEPTH = 1024,
	localparam int ADDR_W   = $clog2(BUF_DEPTH),
	localparam int CNT_W    = $clog2(BUF_DEPTH + 1)
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	output      logic              busy,
	input  wire logic [1:0]        cmd,
	input  wire logic [7:0]        key_byte,
	input  wire logic [ADDR_W-1:0] read_index,
	output      logic              done,
	output      logic [7:0]        char_out,
	output      logic              index_valid,
	output      logic [CNT_W-1:0]  text_length,
	output      logic [CNT_W-1:0]  cursor_pos,
	output      logic              dropped
);

	import kle_pkg::*;

	logic              rd_en, wr_en;
	logic [ADDR_W-1:0] rd_addr, wr_addr;
	logic [7:0]        rd_data, wr_data;
	logic [CNT_W-1:0]  left_count, right_count;
	result_t           result;

	logic              done_q, valid_q, dropped_q;
	logic [7:0]        char_q;
	logic [CNT_W-1:0]  length_q, cursor_q;

	kle_ctrl #(
		.BUF_DEPTH (BUF_DEPTH),
		.ADDR_W    (ADDR_W),
		.CNT_W     (CNT_W)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.cmd         (cmd),
		.key_byte    (key_byte),
		.read_index  (read_index),
		.busy        (busy),
		.rd_en       (rd_en),
		.rd_addr     (rd_addr),
		.rd_data     (rd_data),
		.wr_en       (wr_en),
		.wr_addr     (wr_addr),
		.wr_data     (wr_data),
		.left_count  (left_count),
		.right_count (right_count),
		.result      (result)
	);

	kle_mem #(
		.BUF_DEPTH (BUF_DEPTH),
		.ADDR_W    (ADDR_W)
	) u_mem (
		.clk     (clk),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data)
	);

	// result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= result.fire;
		end
	end

	// result payload, captured at the end of the execute cycle
	always_ff @(posedge clk) begin
		if (result.fire) begin
			char_q    <= result.ch;
			valid_q   <= result.valid;
			dropped_q <= result.dropped;
			length_q  <= left_count + right_count;
			cursor_q  <= left_count;
		end
	end

	assign done        = done_q;
	assign char_out    = char_q;
	assign index_valid = valid_q;
	assign dropped     = dropped_q;
	assign text_length = length_q;
	assign cursor_pos  = cursor_q;

	// checks
	`KLE_ASSERT_NEXT(a_accept_busy, clk, arst_n, start && !busy, busy)
	`KLE_ASSERT_NEXT(a_busy_done, clk, arst_n, busy, done && !busy)
	`KLE_ASSERT_IMPL(a_cursor_in_text, clk, arst_n, done, cursor_pos <= text_length)
	`KLE_ASSERT_IMPL(a_char_zero, clk, arst_n, done && !index_valid, char_out == 8'h00)

endmodule

`default_nettype wire
